[sv/lms_pkg.sv]
// Shared types and constants for the LED matrix scan and PWM block.
`default_nettype none

package lms_pkg;

   // Width of one pixel intensity and of each result field.
   localparam int PIX_W   = 8;
   localparam int FIELD_W = 8;
   // Width of the pixel index field.
   localparam int IDX_W   = 6;

   // Kind of input word.
   typedef enum logic {
      ACT_TICK  = 1'b0,
      ACT_WRITE = 1'b1
   } action_type;

   typedef logic [PIX_W-1:0] pixel_type;

endpackage

`default_nettype wire

[sv/led_matrix_scan_pwm_top.sv]
// LED matrix scanner with per-pixel PWM: pixel store, scan counter and row compare.
// Tick path: the store is read into a register at the accepting edge, and the compare result
// is loaded into the output register when the compare stage drains.
// Ticks may follow each other every cycle unless a pixel write is pending or the output is stalled.
// A pixel write splits the index, then writes the store; input stalls during the store write.
// Synchronous active-high reset clears the scan counter, the pipeline and the per-pixel valid
// bits; an unwritten pixel reads 0, pixel 0 reads 1, so no clearing pass is needed.
`default_nettype none

module led_matrix_scan_pwm_top #(
   parameter int COLUMNS     = 8,
   parameter int ROWS        = 8,
   parameter int PWM_LEVELS  = 16,
   parameter int PIXEL_COUNT = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // input words
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_action,
   input  wire logic [lms_pkg::IDX_W-1:0]    req_pixel_index,
   input  wire logic [lms_pkg::PIX_W-1:0]    req_pixel_value,
   // result words
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [lms_pkg::FIELD_W-1:0]       rsp_column_bits,
   output logic [lms_pkg::FIELD_W-1:0]       rsp_row_bits
);

   localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int PH_W   = (PWM_LEVELS > 1) ? $clog2(PWM_LEVELS) : 1;
   localparam int IDX_W  = lms_pkg::IDX_W;
   // Reciprocal of COLUMNS: index / COLUMNS == (index * RECIP) >> RSHIFT for every 6-bit index.
   localparam int RSHIFT = 16;
   localparam int RECIP  = ((1 << RSHIFT) + COLUMNS - 1) / COLUMNS;
   localparam int PROD_W = IDX_W + RSHIFT;

   localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
   localparam logic [PH_W-1:0]  PH_LAST  = PH_W'(PWM_LEVELS - 1);

   // ------------------------------------------------------------------
   // Handshake decode
   // ------------------------------------------------------------------
   logic req_fire, tick_fire, wr_fire;
   logic s1_ff, s1_in;         // tick read done, compare pending
   logic s1_adv;
   logic rsp_valid_ff, rsp_valid_in;
   logic wr_pend_ff, wr_pend_in;

   assign s1_adv    = s1_ff && (!rsp_valid_ff || rsp_ready);
   // Stall input while a pixel write finishes or the compare stage cannot drain.
   assign req_ready = !wr_pend_ff && (!s1_ff || s1_adv);
   assign req_fire  = req_valid && req_ready;
   assign tick_fire = req_fire && (req_action == lms_pkg::ACT_TICK);
   assign wr_fire   = req_fire && (req_action == lms_pkg::ACT_WRITE);

   // ------------------------------------------------------------------
   // Scan counter: column in the low part, PWM phase in the high part
   // ------------------------------------------------------------------
   logic [COL_W-1:0] col_ff, col_in;
   logic [PH_W-1:0]  phase_ff, phase_in;

   always_comb begin
      col_in   = col_ff;
      phase_in = phase_ff;
      if (tick_fire) begin
         // Advance first; the result uses the advanced count.
         if (col_ff == COL_LAST) begin
            col_in   = '0;
            phase_in = (phase_ff == PH_LAST) ? '0 : phase_ff + 1'b1;
         end else begin
            col_in   = col_ff + 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Pixel store: one word per column, one byte lane per row
   // ------------------------------------------------------------------
   lms_pkg::pixel_type [ROWS-1:0] pix_mem [COLUMNS];
   logic [ROWS-1:0]               pix_vld_ff [COLUMNS];
   lms_pkg::pixel_type [ROWS-1:0] rd_data_ff;
   logic [ROWS-1:0]               rd_vld_ff;

   // Write stage A: split the index into row (by reciprocal multiply) and hold the word.
   logic [PROD_W-1:0]      wr_prod;
   logic [IDX_W-1:0]       wr_q_ff, wr_q_in;
   logic [IDX_W-1:0]       wr_idx_ff, wr_idx_in;
   lms_pkg::pixel_type     wr_val_ff, wr_val_in;

   assign wr_prod   = PROD_W'(req_pixel_index) * PROD_W'(RECIP);
   assign wr_q_in   = wr_fire ? wr_prod[RSHIFT +: IDX_W] : wr_q_ff;
   assign wr_idx_in = wr_fire ? req_pixel_index : wr_idx_ff;
   assign wr_val_in = wr_fire ? req_pixel_value : wr_val_ff;
   assign wr_pend_in = wr_fire;

   // Write stage B: column is the remainder; drop writes outside the store or matrix.
   logic [IDX_W-1:0] wr_col_full;
   logic             wr_en;
   logic [COL_W-1:0] wr_col;
   logic [ROW_W-1:0] wr_row;

   assign wr_col_full = wr_idx_ff - IDX_W'(wr_q_ff * COLUMNS);
   assign wr_col      = wr_col_full[COL_W-1:0];
   assign wr_row      = wr_q_ff[ROW_W-1:0];
   assign wr_en       = wr_pend_ff && (32'(wr_idx_ff) < PIXEL_COUNT) && (32'(wr_q_ff) < ROWS);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pix_mem[wr_col][wr_row] <= wr_val_ff;
      end
      if (tick_fire) begin
         rd_data_ff <= pix_mem[col_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < COLUMNS; c++) begin
            pix_vld_ff[c] <= '0;
         end
      end else if (wr_en) begin
         pix_vld_ff[wr_col][wr_row] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_fire) begin
         rd_vld_ff <= pix_vld_ff[col_in];
      end
   end

   // ------------------------------------------------------------------
   // Compare stage: each row lit when its intensity exceeds the phase
   // ------------------------------------------------------------------
   logic [ROWS-1:0]    row_hit;
   logic [COLUMNS-1:0] col_onehot;
   lms_pkg::pixel_type phase_ext;

   assign phase_ext = lms_pkg::PIX_W'(phase_ff);

   always_comb begin
      lms_pkg::pixel_type pix;
      for (int r = 0; r < ROWS; r++) begin
         if (rd_vld_ff[r]) begin
            pix = rd_data_ff[r];
         end else begin
            // Unwritten pixel holds its reset value: pixel 0 is 1, the rest 0.
            pix = ((r == 0) && (col_ff == '0)) ? lms_pkg::PIX_W'(1) : '0;
         end
         // Pixels past the end of the store read as off.
         row_hit[r] = ((r * COLUMNS + int'(col_ff)) < PIXEL_COUNT) && (pix > phase_ext);
      end
   end

   assign col_onehot = COLUMNS'(1) << col_ff;

   logic [lms_pkg::FIELD_W-1:0] rsp_col_ff, rsp_col_in;
   logic [lms_pkg::FIELD_W-1:0] rsp_row_ff, rsp_row_in;

   // Load the output word when the compare stage drains; drop it once taken.
   assign rsp_col_in   = s1_adv ? lms_pkg::FIELD_W'(col_onehot) : rsp_col_ff;
   assign rsp_row_in   = s1_adv ? lms_pkg::FIELD_W'(row_hit) : rsp_row_ff;
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ready);
   assign s1_in        = tick_fire || (s1_ff && !s1_adv);

   always_ff @(posedge clock) begin
      rsp_col_ff <= rsp_col_in;
      rsp_row_ff <= rsp_row_in;
      wr_q_ff    <= wr_q_in;
      wr_idx_ff  <= wr_idx_in;
      wr_val_ff  <= wr_val_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         phase_ff     <= '0;
         s1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wr_pend_ff   <= 1'b0;
      end else begin
         col_ff       <= col_in;
         phase_ff     <= phase_in;
         s1_ff        <= s1_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_pend_ff   <= wr_pend_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_column_bits = rsp_col_ff;
   assign rsp_row_bits    = rsp_row_ff;

`ifndef SYNTHESIS
   // A pending store write holds off input so a following tick sees it.
   a_wr_interlock: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> !req_ready)
      else $error("input accepted during pending pixel write");

   // An accepted tick always reaches the compare stage next cycle.
   a_tick_to_s1: assert property (@(posedge clock) disable iff (reset)
      tick_fire |=> s1_ff)
      else $error("accepted tick lost before compare");

   // Scan column stays inside the matrix.
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) < COLUMNS)
      else $error("scan column out of range");
`endif

endmodule

`default_nettype wire
